/* rtl/nfde_pkg.sv */
package nfde_pkg;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_SETUP,
		ST_SEG,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_RD,
		ST_RD_CAP,
		ST_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_FILL        = 4'd0,
		OP_PIXEL       = 4'd1,
		OP_HLINE       = 4'd2,
		OP_VLINE_LEFT  = 4'd3,
		OP_VLINE_RIGHT = 4'd4,
		OP_RECT        = 4'd5,
		OP_BLIT_START  = 4'd6,
		OP_BLIT_DATA   = 4'd7,
		OP_READ        = 4'd8
	} op_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BOUNDS   = 2'd1;
	localparam logic [1:0] STATUS_NO_BLIT  = 2'd2;

	localparam logic [7:0] MASK_LOW  = 8'h0F;
	localparam logic [7:0] MASK_HIGH = 8'hF0;
	localparam logic [7:0] MASK_ALL  = 8'hFF;

	localparam logic [1:0] PH_LEFT   = 2'd0;
	localparam logic [1:0] PH_RIGHT  = 2'd1;
	localparam logic [1:0] PH_TOP    = 2'd2;
	localparam logic [1:0] PH_BOTTOM = 2'd3;

endpackage

/* rtl/nibble_framebuffer_draw_engine_core.sv */
// Channel   Direction  Width           Contents
// s_axis    in         tuser 4, tdata 64  command and its arguments
// m_axis    out        tdata 16, tlast 1  status and read byte; tlast ends a blit
//
// Every command returns one transfer. An odd blit byte can take two read-modify-writes
// through the single memory write port. Lines write their clipped length; a rectangle
// writes its four clipped sides in turn. Fill writes all ROW_BYTES*ROW_COUNT bytes, one
// byte a cycle, and the clearing pass after reset writes every byte the same way.
// No command is accepted during a fill or while the previous one is still in progress;
// a stalled result holds in the output register while the next command is taken.
module nibble_framebuffer_draw_engine_core #(
	parameter int ROW_BYTES = 128,
	parameter int ROW_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[3:0]
	input  logic [3:0]  s_axis_tuser,
	// x[7:0], y[13:8], x2[20:14], y2[26:21], length[34:27], rows[41:35],
	// columns[49:42], data_byte[57:50], zero[63:58]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], read_data[9:2], zero[15:10]
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	localparam int DEPTH = ROW_BYTES * ROW_COUNT;
	localparam int AW = $clog2(DEPTH);
	localparam logic [8:0] RB9 = 9'(ROW_BYTES);
	localparam logic [8:0] RC9 = 9'(ROW_COUNT);

	logic [7:0] mem [DEPTH];
	logic [7:0] mem_rdata_q;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0] mem_wdata;

	nfde_pkg::state_t state_q, state_d;

	logic [AW-1:0] ptr_q, rmw_addr_q;
	logic [7:0] fill_q, mask_q;
	logic fill_op_q, b_pend_q, rect_q;
	logic [1:0] phase_q;
	logic [3:0] ln_op_q;
	logic [7:0] rx_q, ln_len_q;
	logic [5:0] ry_q, ry2_q;
	logic [6:0] rx2_q;
	logic [8:0] seg_col_q, seg_row_q, seg_cnt_q;
	logic seg_vert_q;
	logic [7:0] seg_val_q;
	logic [7:0] bx_q, bcols_q, cc_q;
	logic [5:0] by_q;
	logic [6:0] brows_q, rc_q;
	logic bactive_q;
	logic [1:0] res_status_q;
	logic [7:0] res_rd_q;
	logic res_done_q;
	logic out_valid_q, out_done_q;
	logic [1:0] out_status_q;
	logic [7:0] out_rd_q;

	logic [3:0] in_op;
	logic [7:0] in_x, in_len, in_cols, in_d;
	logic [5:0] in_y, in_y2;
	logic [6:0] in_x2, in_rows;
	logic s_fire, out_free, more;
	logic [8:0] px_col, bi_col, bi_row, need;
	logic pix_ok, rd_ok, start_bad, blit_odd, rect_inv;
	logic [8:0] cc_next, rc_next;
	logic row_end, blit_end;
	logic su_vert;
	logic [8:0] su_col, su_row, su_len, su_lim, su_cnt;
	logic [7:0] su_val;

	function automatic logic [AW-1:0] addr_of(input logic [8:0] row, input logic [8:0] col);
		addr_of = AW'(int'(row) * ROW_BYTES + int'(col));
	endfunction

	assign in_op = s_axis_tuser;
	assign in_x = s_axis_tdata[7:0];
	assign in_y = s_axis_tdata[13:8];
	assign in_x2 = s_axis_tdata[20:14];
	assign in_y2 = s_axis_tdata[26:21];
	assign in_len = s_axis_tdata[34:27];
	assign in_rows = s_axis_tdata[41:35];
	assign in_cols = s_axis_tdata[49:42];
	assign in_d = s_axis_tdata[57:50];

	assign s_axis_tready = (state_q == nfde_pkg::ST_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign more = rect_q && (phase_q != nfde_pkg::PH_BOTTOM);

	assign px_col = {2'b0, in_x[7:1]};
	assign pix_ok = (px_col < RB9) && ({3'b0, in_y} < RC9);
	assign rd_ok = ({1'b0, in_x} < RB9) && ({3'b0, in_y} < RC9);
	assign need = 9'(in_x[7:1]) + 9'(in_cols) + 9'(in_x[0]);
	assign start_bad = (need > RB9) || ((9'(in_y) + 9'(in_rows)) > RC9);
	assign rect_inv = ({1'b0, in_x2} < in_x) || (in_y2 < in_y);
	assign bi_col = 9'(bx_q[7:1]) + 9'(cc_q);
	assign bi_row = 9'(by_q) + 9'(rc_q);
	assign blit_odd = bx_q[0];
	assign cc_next = 9'(cc_q) + 9'd1;
	assign rc_next = 9'(rc_q) + 9'd1;
	assign row_end = cc_next >= 9'(bcols_q);
	assign blit_end = row_end && (rc_next >= 9'(brows_q));

	always_comb begin
		su_vert = 1'b0;
		su_col = 9'(rx_q);
		su_row = 9'(ry_q);
		su_len = 9'(ln_len_q);
		su_val = nfde_pkg::MASK_ALL;
		if (rect_q) begin
			unique case (phase_q)
				nfde_pkg::PH_LEFT: begin
					su_vert = 1'b1;
					su_len = 9'(ry2_q) - 9'(ry_q) + 9'd1;
					su_val = nfde_pkg::MASK_HIGH;
				end
				nfde_pkg::PH_RIGHT: begin
					su_vert = 1'b1;
					su_col = 9'(rx2_q);
					su_len = 9'(ry2_q) - 9'(ry_q) + 9'd1;
					su_val = nfde_pkg::MASK_LOW;
				end
				nfde_pkg::PH_TOP: begin
					su_len = 9'(rx2_q) - 9'(rx_q) + 9'd1;
				end
				default: begin
					su_row = 9'(ry2_q);
					su_len = 9'(rx2_q) - 9'(rx_q) + 9'd1;
				end
			endcase
		end else begin
			su_vert = (ln_op_q != nfde_pkg::OP_HLINE);
			if (ln_op_q == nfde_pkg::OP_VLINE_LEFT) begin
				su_val = nfde_pkg::MASK_HIGH;
			end else if (ln_op_q == nfde_pkg::OP_VLINE_RIGHT) begin
				su_val = nfde_pkg::MASK_LOW;
			end
		end
		su_lim = su_vert ? (RC9 - su_row) : (RB9 - su_col);
		if (su_col >= RB9 || su_row >= RC9) begin
			su_cnt = '0;
		end else begin
			su_cnt = (su_len < su_lim) ? su_len : su_lim;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nfde_pkg::ST_FILL: begin
				if (ptr_q == AW'(DEPTH - 1)) begin
					state_d = fill_op_q ? nfde_pkg::ST_RESP : nfde_pkg::ST_IDLE;
				end
			end
			nfde_pkg::ST_IDLE: begin
				if (s_fire) begin
					case (in_op)
						nfde_pkg::OP_FILL: state_d = nfde_pkg::ST_FILL;
						nfde_pkg::OP_PIXEL:
							state_d = pix_ok ? nfde_pkg::ST_RMW_RD : nfde_pkg::ST_RESP;
						nfde_pkg::OP_HLINE, nfde_pkg::OP_VLINE_LEFT,
						nfde_pkg::OP_VLINE_RIGHT: state_d = nfde_pkg::ST_SETUP;
						nfde_pkg::OP_RECT:
							state_d = rect_inv ? nfde_pkg::ST_RESP : nfde_pkg::ST_SETUP;
						nfde_pkg::OP_BLIT_DATA:
							state_d = (bactive_q && blit_odd && in_d != 8'h00) ?
								nfde_pkg::ST_RMW_RD : nfde_pkg::ST_RESP;
						nfde_pkg::OP_READ:
							state_d = rd_ok ? nfde_pkg::ST_RD : nfde_pkg::ST_RESP;
						default: state_d = nfde_pkg::ST_RESP;
					endcase
				end
			end
			nfde_pkg::ST_SETUP: begin
				if (su_cnt != 9'd0) begin
					state_d = nfde_pkg::ST_SEG;
				end else if (!more) begin
					state_d = nfde_pkg::ST_RESP;
				end
			end
			nfde_pkg::ST_SEG: begin
				if (seg_cnt_q == 9'd1) begin
					state_d = more ? nfde_pkg::ST_SETUP : nfde_pkg::ST_RESP;
				end
			end
			nfde_pkg::ST_RMW_RD: state_d = nfde_pkg::ST_RMW_WR;
			nfde_pkg::ST_RMW_WR:
				state_d = b_pend_q ? nfde_pkg::ST_RMW_RD : nfde_pkg::ST_RESP;
			nfde_pkg::ST_RD: state_d = nfde_pkg::ST_RD_CAP;
			nfde_pkg::ST_RD_CAP: state_d = nfde_pkg::ST_RESP;
			nfde_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = nfde_pkg::ST_IDLE;
				end
			end
			default: state_d = nfde_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = fill_q;
		unique case (state_q)
			nfde_pkg::ST_FILL: begin
				mem_we = 1'b1;
			end
			nfde_pkg::ST_SEG: begin
				mem_we = 1'b1;
				mem_waddr = addr_of(seg_row_q, seg_col_q);
				mem_wdata = seg_val_q;
			end
			nfde_pkg::ST_RMW_WR: begin
				mem_we = 1'b1;
				mem_waddr = rmw_addr_q;
				mem_wdata = mem_rdata_q | mask_q;
			end
			nfde_pkg::ST_IDLE: begin
				mem_we = s_fire && (in_op == nfde_pkg::OP_BLIT_DATA) && bactive_q && !blit_odd;
				mem_waddr = addr_of(bi_row, bi_col);
				mem_wdata = in_d;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[rmw_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfde_pkg::ST_FILL;
			ptr_q <= '0;
			fill_q <= '0;
			fill_op_q <= 1'b0;
			bactive_q <= 1'b0;
			bx_q <= '0;
			by_q <= '0;
			brows_q <= '0;
			bcols_q <= '0;
			rc_q <= '0;
			cc_q <= '0;
			out_valid_q <= 1'b0;
			rect_q <= 1'b0;
			phase_q <= nfde_pkg::PH_LEFT;
			b_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == nfde_pkg::ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				nfde_pkg::ST_FILL: begin
					ptr_q <= (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
				end
				nfde_pkg::ST_IDLE: begin
					if (s_fire) begin
						res_status_q <= nfde_pkg::STATUS_OK;
						res_rd_q <= '0;
						res_done_q <= 1'b0;
						rect_q <= (in_op == nfde_pkg::OP_RECT);
						phase_q <= nfde_pkg::PH_LEFT;
						ln_op_q <= in_op;
						rx_q <= in_x;
						ry_q <= in_y;
						rx2_q <= in_x2;
						ry2_q <= in_y2;
						ln_len_q <= in_len;
						b_pend_q <= 1'b0;
						case (in_op)
							nfde_pkg::OP_FILL: begin
								fill_q <= in_d;
								fill_op_q <= 1'b1;
								ptr_q <= '0;
							end
							nfde_pkg::OP_PIXEL: begin
								rmw_addr_q <= addr_of(9'(in_y), px_col);
								mask_q <= in_x[0] ? nfde_pkg::MASK_LOW : nfde_pkg::MASK_HIGH;
							end
							nfde_pkg::OP_READ: begin
								rmw_addr_q <= addr_of(9'(in_y), 9'(in_x));
							end
							nfde_pkg::OP_BLIT_START: begin
								if (start_bad) begin
									res_status_q <= nfde_pkg::STATUS_BOUNDS;
									bactive_q <= 1'b0;
								end else begin
									bx_q <= in_x;
									by_q <= in_y;
									brows_q <= in_rows;
									bcols_q <= in_cols;
									rc_q <= '0;
									cc_q <= '0;
									bactive_q <= (in_rows != 7'd0) && (in_cols != 8'd0);
								end
							end
							nfde_pkg::OP_BLIT_DATA: begin
								if (!bactive_q) begin
									res_status_q <= nfde_pkg::STATUS_NO_BLIT;
								end else begin
									if (in_d[7:4] != 4'd0) begin
										rmw_addr_q <= addr_of(bi_row, bi_col);
										mask_q <= nfde_pkg::MASK_LOW;
										b_pend_q <= (in_d[3:0] != 4'd0);
									end else begin
										rmw_addr_q <= addr_of(bi_row, bi_col + 9'd1);
										mask_q <= nfde_pkg::MASK_HIGH;
									end
									if (blit_end) begin
										cc_q <= '0;
										rc_q <= '0;
										bactive_q <= 1'b0;
										res_done_q <= 1'b1;
									end else if (row_end) begin
										cc_q <= '0;
										rc_q <= 7'(rc_next);
									end else begin
										cc_q <= 8'(cc_next);
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				nfde_pkg::ST_SETUP: begin
					seg_vert_q <= su_vert;
					seg_col_q <= su_col;
					seg_row_q <= su_row;
					seg_cnt_q <= su_cnt;
					seg_val_q <= su_val;
					if (su_cnt == 9'd0 && more) begin
						phase_q <= phase_q + 2'd1;
					end
				end
				nfde_pkg::ST_SEG: begin
					seg_cnt_q <= seg_cnt_q - 9'd1;
					if (seg_vert_q) begin
						seg_row_q <= seg_row_q + 9'd1;
					end else begin
						seg_col_q <= seg_col_q + 9'd1;
					end
					if (seg_cnt_q == 9'd1 && more) begin
						phase_q <= phase_q + 2'd1;
					end
				end
				nfde_pkg::ST_RMW_WR: begin
					if (b_pend_q) begin
						b_pend_q <= 1'b0;
						rmw_addr_q <= rmw_addr_q + AW'(1);
						mask_q <= nfde_pkg::MASK_HIGH;
					end
				end
				nfde_pkg::ST_RD_CAP: begin
					res_rd_q <= mem_rdata_q;
				end
				nfde_pkg::ST_RESP: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_rd_q <= res_rd_q;
						out_done_q <= res_done_q;
						fill_op_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'b0, out_rd_q, out_status_q};
	assign m_axis_tlast = out_done_q;

	a_no_write_in_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nfde_pkg::ST_RESP |-> !mem_we)
		else $error("frame store written while a result is pending");

	a_done_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == nfde_pkg::STATUS_OK)
		else $error("blit completion reported with an error status");

	a_blit_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		bactive_q |-> (rc_q < brows_q) && (cc_q < bcols_q))
		else $error("blit position outside its area");

	a_rmw_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nfde_pkg::ST_RMW_RD |=> state_q == nfde_pkg::ST_RMW_WR)
		else $error("read-modify-write lost its write cycle");

endmodule
